>>> hw/rtl/ccrc_pkg.sv
// Shared types, register codes, reset values and helper functions for the
// configurable CRC engine. Has no dependencies; every other RTL file imports it.
`default_nettype none

package ccrc_pkg;

    // Payload and configuration widths.
    localparam int CRC_W     = 64;
    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 3;

    typedef logic [1:0]       width_sel_t;
    typedef logic [CRC_W-1:0] crc_word_t;

    // Width selector codes.
    localparam width_sel_t WSEL_8  = 2'd0;
    localparam width_sel_t WSEL_16 = 2'd1;
    localparam width_sel_t WSEL_32 = 2'd2;
    localparam width_sel_t WSEL_64 = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SELECT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECTED_ORDER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_TAPS         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_XOR         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RESULT_BYTES = 3'd5;

    // Register values after reset (reflected CRC-32).
    localparam width_sel_t RST_WIDTH_SELECT = WSEL_32;
    localparam logic       RST_REFLECTED    = 1'b1;
    localparam crc_word_t  RST_POLY_TAPS    = 64'h0000_0000_EDB8_8320;
    localparam crc_word_t  RST_START_VALUE  = 64'h0000_0000_FFFF_FFFF;
    localparam crc_word_t  RST_FINAL_XOR    = 64'h0000_0000_FFFF_FFFF;
    localparam logic       RST_SWAP_BYTES   = 1'b0;

    // Shift mode handed to the byte update logic.
    typedef struct packed {
        width_sel_t width_sel;
        logic       reflected;
    } crc_mode_t;

    // Mask covering the selected CRC width.
    function automatic crc_word_t width_mask(input width_sel_t wsel);
        crc_word_t m;
        case (wsel)
            WSEL_8:  m = 64'h0000_0000_0000_00FF;
            WSEL_16: m = 64'h0000_0000_0000_FFFF;
            WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Reverse the byte order of a value within the selected width.
    function automatic crc_word_t swap_bytes(input crc_word_t v, input width_sel_t wsel);
        crc_word_t r;
        case (wsel)
            WSEL_8:  r = {56'd0, v[7:0]};
            WSEL_16: r = {48'd0, v[7:0], v[15:8]};
            WSEL_32: r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
            default: r = {v[7:0], v[15:8], v[23:16], v[31:24],
                          v[39:32], v[47:40], v[55:48], v[63:56]};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ccrc_step.sv
// Combinational one-byte CRC update: eight XOR-shift steps in either bit order.
// Depends on ccrc_pkg for the mode struct and width helpers.
`default_nettype none

module ccrc_step
    import ccrc_pkg::*;
(
    input  wire crc_mode_t mode,
    input  wire crc_word_t poly,
    input  wire crc_word_t crc_in,
    input  wire [DATA_W-1:0] data_byte,
    output crc_word_t      crc_out
);

    crc_word_t  mask;
    crc_word_t  poly_m;
    crc_word_t  poly_al;
    crc_word_t  refl;
    crc_word_t  norm;
    logic [5:0] align;

    // Normal order runs left-aligned in the 64-bit word, so the top bit is
    // always bit 63 whatever the selected width.
    always_comb
    begin
        mask   = width_mask(mode.width_sel);
        poly_m = poly & mask;
        case (mode.width_sel)
            WSEL_8:  align = 6'd56;
            WSEL_16: align = 6'd48;
            WSEL_32: align = 6'd32;
            default: align = 6'd0;
        endcase

        // Reflected order: byte enters at the low end, shift right.
        refl = (crc_in & mask) ^ {56'd0, data_byte};
        for (int k = 0; k < DATA_W; k++)
        begin
            refl = refl[0] ? ((refl >> 1) ^ poly_m) : (refl >> 1);
        end

        // Normal order: byte enters under the top bit, shift left.
        poly_al = poly_m << align;
        norm    = ((crc_in & mask) << align) ^ {data_byte, 56'd0};
        for (int k = 0; k < DATA_W; k++)
        begin
            norm = norm[CRC_W-1] ? ((norm << 1) ^ poly_al) : (norm << 1);
        end

        crc_out = mode.reflected ? refl : (norm >> align);
    end

endmodule

`default_nettype wire

>>> hw/rtl/configurable_crc_engine_core.sv
// A result is offered on the output once the transaction that closes the message
// has passed through the input register and then the result register.
// Throughput: one byte per cycle; the running CRC feeds back through the
// eight-step byte update combinationally. A closing transaction waits in the
// input register only while the result register holds an untaken result.
// Reset: rst_n is asynchronous and active low; it restores the CRC-32 setup
// and empties both pipeline registers. Depends on ccrc_pkg and ccrc_step.
`default_nettype none

module configurable_crc_engine_core
    import ccrc_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,

    // Configuration write port.
    input  wire                 cfg_we,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [CRC_W-1:0]     cfg_data,

    // Input byte stream.
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire [DATA_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  wire [0:0]           s_axis_tuser,   // [0] byte_present
    input  wire                 s_axis_tlast,   // end_of_message

    // Result stream.
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [CRC_W-1:0]    m_axis_tdata    // [63:0] crc_result
);

    // Configuration registers.
    width_sel_t width_sel_reg;
    logic       reflected_reg;
    crc_word_t  poly_reg;
    crc_word_t  start_reg;
    crc_word_t  final_xor_reg;
    logic       swap_reg;

    // Input register.
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_present_reg;
    logic              in_last_reg;

    // Running state and result register.
    crc_word_t crc_reg;
    crc_word_t crc_next;
    logic      awaiting_reg;
    logic      out_valid_reg;
    crc_word_t out_data_reg;
    crc_word_t out_data_next;

    crc_mode_t mode;
    crc_word_t mask;
    crc_word_t base_crc;
    crc_word_t stepped_crc;
    crc_word_t final_crc;
    logic      out_free;
    logic      advance;
    logic      active;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_sel_reg <= RST_WIDTH_SELECT;
            reflected_reg <= RST_REFLECTED;
            poly_reg      <= RST_POLY_TAPS;
            start_reg     <= RST_START_VALUE;
            final_xor_reg <= RST_FINAL_XOR;
            swap_reg      <= RST_SWAP_BYTES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH_SELECT:      width_sel_reg <= cfg_data[1:0];
                CFG_REFLECTED_ORDER:   reflected_reg <= cfg_data[0];
                CFG_POLY_TAPS:         poly_reg      <= cfg_data;
                CFG_START_VALUE:       start_reg     <= cfg_data;
                CFG_FINAL_XOR:         final_xor_reg <= cfg_data;
                CFG_SWAP_RESULT_BYTES: swap_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The held transaction moves on unless it needs the result register
    // while that register still holds an untaken result.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign active        = advance && (in_present_reg || in_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg    <= s_axis_tdata;
            in_present_reg <= s_axis_tuser[0];
            in_last_reg    <= s_axis_tlast;
        end
    end

    // Byte update on the running register, or on the start value for the
    // first transaction of a message.
    assign mode = '{width_sel: width_sel_reg, reflected: reflected_reg};
    assign mask = width_mask(width_sel_reg);

    assign base_crc = awaiting_reg ? (start_reg & mask) : crc_reg;

    ccrc_step u_step (
        .mode      (mode),
        .poly      (poly_reg),
        .crc_in    (base_crc),
        .data_byte (in_data_reg),
        .crc_out   (stepped_crc)
    );

    assign crc_next  = in_present_reg ? stepped_crc : base_crc;
    assign final_crc = (crc_next ^ final_xor_reg) & mask;
    assign out_data_next = swap_reg ? swap_bytes(final_crc, width_sel_reg) : final_crc;

    // Running state: a closing transaction rearms the start load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= '0;
            awaiting_reg <= 1'b1;
        end
        else if (active)
        begin
            crc_reg      <= crc_next;
            awaiting_reg <= in_last_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ccrc_checker.sv
// Port-level checker for the configurable CRC engine, bound to the top level.
// Depends on ccrc_pkg for widths.
`default_nettype none

module ccrc_checker
    import ccrc_pkg::*;
(
    input wire              clk,
    input wire              rst_n,
    input wire              s_axis_tready,
    input wire              m_axis_tvalid,
    input wire              m_axis_tready,
    input wire [CRC_W-1:0]  m_axis_tdata
);

    // A stalled result transaction keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The input side only stalls behind an untaken result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // No result is offered right after reset is released.
    assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !m_axis_tvalid)
        else $error("result valid directly after reset");

    // With no result offered, the input side is always ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with empty output");

endmodule

bind configurable_crc_engine_core ccrc_checker u_ccrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for configurable_crc_engine_core: streams message bytes,
// predicts each CRC in a bit-accurate software copy of the engine and checks results.
// Depends on ccrc_pkg for port widths, width selector codes and register indexes.
`timescale 1ns / 100ps

module tb_top;
    import ccrc_pkg::*;

    localparam int CLK_HALF          = 6;
    localparam int RESET_CYCLES      = 6;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int HOLD_LEN          = 150;
    localparam int RESULT_WAIT_LIMIT = HOLD_LEN + 100;
    localparam int SETTLE_CYCLES     = 4;
    localparam int RANDOM_PHASES     = 11;
    localparam int ITEMS_PER_PHASE   = 40;

    // Register index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    // One input transaction: a message byte and its control flags.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              present;
        logic              last;
    } crc_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CRC_W-1:0]     cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;    // [7:0] data_byte
    logic [0:0]           s_axis_tuser = '0;    // [0] byte_present
    logic                 s_axis_tlast = 1'b0;  // end_of_message
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CRC_W-1:0]     m_axis_tdata;         // [63:0] crc_result

    // Copy of the engine's configuration and running state.
    width_sel_t crc_width_sel = RST_WIDTH_SELECT;
    logic       crc_reflect   = RST_REFLECTED;
    crc_word_t  crc_poly      = RST_POLY_TAPS;
    crc_word_t  crc_init      = RST_START_VALUE;
    crc_word_t  crc_xorout    = RST_FINAL_XOR;
    logic       crc_byteswap  = RST_SWAP_BYTES;
    crc_word_t  crc_acc       = '0;
    bit         crc_msg_idle  = 1'b1;

    crc_item_t  pending_items[$];
    crc_word_t  expected_crcs[$];

    crc_item_t  src_item;
    crc_word_t  src_result;
    int         src_gap_left   = 0;
    int         src_gap_max    = 0;
    int         sink_stall_left = 0;
    int         sink_stall_max  = 0;
    int         sink_hold_left  = 0;
    int         hold_requests   = 0;
    int         hold_served     = 0;
    crc_word_t  mon_expected;
    int         error_count = 0;
    int         cycle_count = 0;

    configurable_crc_engine_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Mask of the bits that belong to a CRC of the given width.
    function automatic crc_word_t crc_width_mask(input width_sel_t w);
        int nbits;
        nbits = 8 << w;
        return (w == WSEL_64) ? '1 : ((crc_word_t'(1) << nbits) - 1);
    endfunction

    // Run one byte through eight shift steps in the current bit order.
    function automatic crc_word_t crc_feed_byte(input crc_word_t acc, input logic [7:0] b);
        crc_word_t m;
        crc_word_t p;
        crc_word_t r;
        int        nbits;
        m     = crc_width_mask(crc_width_sel);
        p     = crc_poly & m;
        nbits = 8 << crc_width_sel;
        r     = acc & m;
        if (crc_reflect) begin
            r ^= crc_word_t'(b);
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
        end
        else begin
            r ^= crc_word_t'(b) << (nbits - 8);
            for (int k = 0; k < 8; k++)
                r = r[nbits-1] ? (((r << 1) ^ p) & m) : ((r << 1) & m);
        end
        return r & m;
    endfunction

    // Reverse the byte order within the current width.
    function automatic crc_word_t reverse_crc_bytes(input crc_word_t v);
        crc_word_t r;
        int        nb;
        nb = 1 << crc_width_sel;
        r  = '0;
        for (int i = 0; i < nb; i++)
            r[8*(nb-1-i) +: 8] = v[8*i +: 8];
        return r;
    endfunction

    // Advance the CRC copy by one transaction; returns 1 when a CRC is due.
    function automatic bit predict_crc(input crc_item_t it, output crc_word_t res);
        crc_word_t m;
        m   = crc_width_mask(crc_width_sel);
        res = '0;
        if (!it.present && !it.last)
            return 1'b0;
        if (crc_msg_idle) begin
            crc_acc      = crc_init & m;
            crc_msg_idle = 1'b0;
        end
        if (it.present)
            crc_acc = crc_feed_byte(crc_acc, it.data);
        if (!it.last)
            return 1'b0;
        res = (crc_acc ^ crc_xorout) & m;
        if (crc_byteswap)
            res = reverse_crc_bytes(res);
        res &= m;
        crc_msg_idle = 1'b1;
        return 1'b1;
    endfunction

    // Mostly random words, with all-zero and all-one values now and then.
    function automatic crc_word_t pick_cfg_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Write one register and update the copy of the configuration.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input crc_word_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_WIDTH_SELECT:      crc_width_sel = val[1:0];
            CFG_REFLECTED_ORDER:   crc_reflect   = val[0];
            CFG_POLY_TAPS:         crc_poly      = val;
            CFG_START_VALUE:       crc_init      = val;
            CFG_FINAL_XOR:         crc_xorout    = val;
            CFG_SWAP_RESULT_BYTES: crc_byteswap  = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Write the whole setup; junk fills the unused upper bits of the narrow registers.
    task automatic set_crc(input width_sel_t w, input bit refl, input crc_word_t poly,
                           input crc_word_t init, input crc_word_t xorout, input bit swap,
                           input crc_word_t junk);
        write_reg(CFG_WIDTH_SELECT, (junk & ~crc_word_t'(3)) | crc_word_t'(w));
        write_reg(CFG_REFLECTED_ORDER, (junk & ~crc_word_t'(1)) | crc_word_t'(refl));
        write_reg(CFG_POLY_TAPS, poly);
        write_reg(CFG_START_VALUE, init);
        write_reg(CFG_FINAL_XOR, xorout);
        write_reg(CFG_SWAP_RESULT_BYTES, (junk & ~crc_word_t'(1)) | crc_word_t'(swap));
    endtask

    task automatic add_item(input logic [7:0] d, input bit p, input bit l);
        crc_item_t it;
        it.data    = d;
        it.present = p;
        it.last    = l;
        pending_items.push_back(it);
    endtask

    // Let the sender run dry, collect every outstanding CRC, then let the pipeline settle.
    // The checks run at the falling edge so that the driver's updates have all landed.
    task automatic wait_drain();
        int waited;
        waited = 0;
        while (pending_items.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        while (expected_crcs.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (expected_crcs.size() != 0) begin
            $error("%0d expected crc_result values never arrived", expected_crcs.size());
            error_count++;
            expected_crcs.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input driver: offers queued transactions and predicts each accepted one.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap_left = 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (predict_crc(src_item, src_result))
                    expected_crcs.push_back(src_result);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap_left > 0) begin
                    src_gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    src_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= src_item.data;
                    s_axis_tuser  <= src_item.present;
                    s_axis_tlast  <= src_item.last;
                    src_gap_left = $urandom_range(0, src_gap_max);
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every CRC and applies back-pressure.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall_left = 0;
            sink_hold_left  = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_crcs.size() == 0) begin
                    $error("unexpected result transaction: crc_result %h", m_axis_tdata);
                    error_count++;
                end
                else begin
                    mon_expected = expected_crcs.pop_front();
                    if (m_axis_tdata !== mon_expected) begin
                        $error("crc_result mismatch: expected %h, actual %h",
                               mon_expected, m_axis_tdata);
                        error_count++;
                    end
                end
                sink_stall_left = $urandom_range(0, sink_stall_max);
            end
            if (hold_served != hold_requests) begin
                hold_served    = hold_requests;
                sink_hold_left = HOLD_LEN;
            end
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Timeout: a correct run ends far below this count.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL configurable_crc_engine_core");
        $finish;
    end

    // Stimulus: directed messages first, then random phases with fresh setups.
    initial begin : stimulus
        int         phase;
        int         count;
        int         n;
        bit         closing;
        string      msg;
        width_sel_t wsel;
        crc_word_t  junk;
        crc_word_t  poly;
        crc_word_t  init;
        crc_word_t  xorout;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setup (reflected CRC-32): check string, empty message, idle, byte extremes.
        msg = "123456789";
        for (int i = 0; i < msg.len(); i++)
            add_item(msg[i], 1'b1, i == msg.len() - 1);
        add_item(8'hFF, 1'b0, 1'b1);
        add_item(8'h5A, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1);
        add_item(8'h00, 1'b1, 1'b1);
        wait_drain();

        // Normal-order CRC-8 with wide values and a byte swap that must do nothing;
        // the message closes on a finish-only transaction, then one is left open.
        set_crc(WSEL_8, 1'b0, 64'hFFFF_FFFF_FFFF_FF07, 64'hFFFF_FFFF_FFFF_FF00,
                64'h5555_5555_5555_55AA, 1'b1, '0);
        add_item(8'hA5, 1'b1, 1'b0);
        add_item(8'h5A, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h31, 1'b1, 1'b0);
        add_item(8'h32, 1'b1, 1'b0);
        wait_drain();

        // Switch to reflected CRC-64 in the middle of the open message.
        set_crc(WSEL_64, 1'b1, 64'hC96C_5795_D787_0F42, '1, '1, 1'b1, '0);
        add_item(8'h33, 1'b1, 1'b0);
        add_item(8'h34, 1'b1, 1'b1);
        add_item(8'hFF, 1'b1, 1'b1);
        wait_drain();

        // A write to an unmapped index, then normal-order CRC-16.
        write_reg(CFG_UNMAPPED, '1);
        set_crc(WSEL_16, 1'b0, 64'h0000_0000_0000_1021, '0, '0, 1'b0, '0);
        add_item(8'h31, 1'b1, 1'b0);
        add_item(8'h32, 1'b1, 1'b0);
        add_item(8'h33, 1'b1, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);
        wait_drain();

        // Random phases.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wsel   = (phase < 4) ? width_sel_t'(phase) : width_sel_t'($urandom_range(0, 3));
            junk   = {$urandom, $urandom};
            poly   = pick_cfg_word();
            init   = pick_cfg_word();
            xorout = pick_cfg_word();
            if (phase == 4) begin
                poly   = '1;
                init   = '1;
                xorout = '1;
            end
            else if (phase == 5) begin
                poly   = '0;
                init   = '0;
                xorout = '0;
            end
            set_crc(wsel, 1'($urandom_range(0, 1)), poly, init, xorout,
                    1'($urandom_range(0, 1)), junk);

            // Every third phase runs without any idling on either side.
            src_gap_max    = (phase % 3 == 0) ? 0 : 4;
            sink_stall_max = (phase % 3 == 0) ? 0 : 4;

            // Long receiver hold while the sender keeps offering back to back.
            if (phase == 2 || phase == 7) begin
                src_gap_max = 0;
                @(posedge clk);
                hold_requests <= hold_requests + 1;
            end

            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                n       = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
                closing = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    add_item(8'($urandom_range(0, 255)), 1'b1, (i == n - 1) && !closing);
                    count++;
                end
                if (n == 0 || closing) begin
                    add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                    count++;
                end
            end

            // Sometimes leave a message open across the next setup change.
            if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            wait_drain();
        end

        if (error_count == 0)
            $display("PASS configurable_crc_engine_core");
        else
            $display("FAIL configurable_crc_engine_core");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ccrc_pkg.sv
hw/rtl/ccrc_step.sv
hw/rtl/configurable_crc_engine_core.sv
hw/rtl/ccrc_checker.sv
tb/sv/tb_top.sv
